// ===== design/miller_rabin_primality_test_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the primality test unit
// ---------------------------------------------------------------------------
`ifndef MILLER_RABIN_PRIMALITY_TEST_UNIT_MACROS_SVH
`define MILLER_RABIN_PRIMALITY_TEST_UNIT_MACROS_SVH

// Check an implication every clock, quiet during reset
`define MR_ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Check an implication on the following clock
`define MR_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ===== design/mrpt_pkg.sv =====
// ---------------------------------------------------------------------------
// mrpt_pkg
// Shared constants and types of the primality test unit.
// ---------------------------------------------------------------------------
`default_nettype none
package mrpt_pkg;
   localparam int Width    = 64;
   localparam int NumBases = 13;
   localparam int BaseW    = 6;
   localparam int IdxW     = 4;
   localparam int RW       = 6;
   localparam int BitW     = 6;

   typedef logic [Width-1:0] word_type;

   // Classification passed from front to back
   localparam logic [1:0] CLS_COMPOSITE = 2'd0;
   localparam logic [1:0] CLS_PRIME     = 2'd1;
   localparam logic [1:0] CLS_TEST      = 2'd2;

   typedef struct packed {
      logic [1:0]      cls;
      word_type        x;
      word_type        d;
      logic [RW-1:0]   r;
   } job_type;

   function automatic logic [BaseW-1:0] base_at(input logic [IdxW-1:0] i);
      logic [BaseW-1:0] b;
      case (i)
         4'd0:    b = 6'd2;
         4'd1:    b = 6'd3;
         4'd2:    b = 6'd5;
         4'd3:    b = 6'd7;
         4'd4:    b = 6'd11;
         4'd5:    b = 6'd13;
         4'd6:    b = 6'd17;
         4'd7:    b = 6'd19;
         4'd8:    b = 6'd23;
         4'd9:    b = 6'd29;
         4'd10:   b = 6'd31;
         4'd11:   b = 6'd37;
         4'd12:   b = 6'd41;
         default: b = 6'd41;
      endcase
      return b;
   endfunction
endpackage
`default_nettype wire

// ===== design/mrpt_if.sv =====
// ---------------------------------------------------------------------------
// mrpt_if
// Valid/ready channel carrying one payload word.
// ---------------------------------------------------------------------------
`default_nettype none
interface mrpt_if #(parameter int W = 1);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/mrpt_front.sv =====
// ---------------------------------------------------------------------------
// mrpt_front
// Accept candidates, classify them and split x-1 into 2^r*d one bit a cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module mrpt_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire mrpt_pkg::word_type  in_cand,
   output logic                     job_valid,
   input  wire logic                job_ready,
   output mrpt_pkg::job_type        job
);
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   mrpt_pkg::job_type          job_ff, job_in;

   assign in_ready  = !busy_ff;
   assign job_valid = done_ff;
   assign job       = job_ff;

   // Classify on accept, then shift d down until odd
   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      job_in  = job_ff;
      if (in_valid && in_ready) begin
         busy_in   = 1'b1;
         job_in.x  = in_cand;
         job_in.d  = in_cand - mrpt_pkg::word_type'(1);
         job_in.r  = '0;
         if (in_cand <= mrpt_pkg::word_type'(1) ||
             (in_cand[0] == 1'b0 && in_cand != mrpt_pkg::word_type'(2))) begin
            job_in.cls = mrpt_pkg::CLS_COMPOSITE;
            done_in    = 1'b1;
         end else if (in_cand == mrpt_pkg::word_type'(2)) begin
            job_in.cls = mrpt_pkg::CLS_PRIME;
            done_in    = 1'b1;
         end else begin
            job_in.cls = mrpt_pkg::CLS_TEST;
            done_in    = 1'b0;
         end
      end else if (busy_ff && !done_ff) begin
         if (job_ff.d[0]) begin
            done_in = 1'b1;
         end else begin
            job_in.d = job_ff.d >> 1;
            job_in.r = job_ff.r + mrpt_pkg::RW'(1);
         end
      end else if (done_ff && job_ready) begin
         done_in = 1'b0;
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      job_ff <= job_in;
   end
endmodule
`default_nettype wire

// ===== design/mrpt_queue.sv =====
// ---------------------------------------------------------------------------
// mrpt_queue
// Two-entry queue of classified jobs between front and back.
// ---------------------------------------------------------------------------
`default_nettype none
module mrpt_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               wr_valid,
   output logic                    wr_ready,
   input  wire mrpt_pkg::job_type  wr_job,
   output logic                    rd_valid,
   input  wire logic               rd_ready,
   output mrpt_pkg::job_type       rd_job
);
   mrpt_pkg::job_type mem_ff [2];
   logic              wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              push, pop;

   assign wr_ready = cnt_ff != 2'd2;
   assign rd_valid = cnt_ff != 2'd0;
   assign rd_job   = mem_ff[rp_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   // Advance pointers and count
   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= wr_job;
      end
   end
endmodule
`default_nettype wire

// ===== design/mrpt_mulmod.sv =====
// ---------------------------------------------------------------------------
// mrpt_mulmod
// Shift-and-add modular multiplier, one multiplier bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module mrpt_mulmod (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire mrpt_pkg::word_type a,
   input  wire mrpt_pkg::word_type b,
   input  wire mrpt_pkg::word_type m,
   output logic                    done,
   output mrpt_pkg::word_type      p
);
   logic                      run_ff, run_in;
   logic                      done_ff, done_in;
   logic [mrpt_pkg::BitW-1:0] bit_ff, bit_in;
   mrpt_pkg::word_type        acc_ff, acc_in, a_ff, b_ff, m_ff;
   mrpt_pkg::word_type        dbl, sum;
   logic [mrpt_pkg::Width:0]  t1, t2;

   assign done = done_ff;
   assign p    = acc_ff;

   // Double, then add a when the bit is set, both reduced by one subtract
   always_comb begin
      t1  = {1'b0, acc_ff} + {1'b0, acc_ff};
      dbl = (t1 >= {1'b0, m_ff}) ? mrpt_pkg::word_type'(t1 - {1'b0, m_ff})
                                 : t1[mrpt_pkg::Width-1:0];
      t2  = {1'b0, dbl} + {1'b0, a_ff};
      sum = (t2 >= {1'b0, m_ff}) ? mrpt_pkg::word_type'(t2 - {1'b0, m_ff})
                                 : t2[mrpt_pkg::Width-1:0];
      run_in  = run_ff;
      done_in = 1'b0;
      bit_in  = bit_ff;
      acc_in  = acc_ff;
      if (start) begin
         run_in = 1'b1;
         bit_in = mrpt_pkg::BitW'(mrpt_pkg::Width - 1);
         acc_in = '0;
      end else if (run_ff) begin
         acc_in = b_ff[bit_ff] ? sum : dbl;
         bit_in = bit_ff - mrpt_pkg::BitW'(1);
         if (bit_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      bit_ff <= bit_in;
      acc_ff <= acc_in;
      if (start) begin
         a_ff <= a;
         b_ff <= b;
         m_ff <= m;
      end
   end
endmodule
`default_nettype wire

// ===== design/mrpt_back.sv =====
// ---------------------------------------------------------------------------
// mrpt_back
// Run the witness rounds of one job on the shared modular multiplier.
// ---------------------------------------------------------------------------
`default_nettype none
module mrpt_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               job_valid,
   output logic                    job_ready,
   input  wire mrpt_pkg::job_type  job,
   output logic                    res_valid,
   input  wire logic               res_ready,
   output logic                    res_prime
);
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_BASE  = 3'd1;
   localparam logic [2:0] S_EXP   = 3'd2;
   localparam logic [2:0] S_CHECK = 3'd3;
   localparam logic [2:0] S_SQR   = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0]                state_ff, state_in;
   logic                      wait_ff, wait_in;
   logic                      sqmul_ff, sqmul_in;
   logic                      prime_ff, prime_in;
   logic [mrpt_pkg::IdxW-1:0] idx_ff, idx_in;
   logic [mrpt_pkg::RW-1:0]   i_ff, i_in;
   mrpt_pkg::word_type        x_ff, x_in, d_ff, d_in, e_ff, e_in;
   mrpt_pkg::word_type        y_ff, y_in, sq_ff, sq_in;
   logic [mrpt_pkg::RW-1:0]   r_ff, r_in;
   logic                      mstart;
   mrpt_pkg::word_type        ma, mb, mp;
   logic                      mdone;
   mrpt_pkg::word_type        base;

   mrpt_mulmod u_mul (
      .clock (clock), .reset (reset), .start (mstart),
      .a (ma), .b (mb), .m (x_ff), .done (mdone), .p (mp)
   );

   assign job_ready = state_ff == S_IDLE;
   assign res_valid = state_ff == S_OUT;
   assign res_prime = prime_ff;
   assign base      = mrpt_pkg::word_type'(mrpt_pkg::base_at(idx_ff));

   // Sequence bases, exponent bits and squarings
   always_comb begin
      state_in = state_ff;
      wait_in  = wait_ff;
      sqmul_in = sqmul_ff;
      prime_in = prime_ff;
      idx_in   = idx_ff;
      i_in     = i_ff;
      x_in     = x_ff;
      d_in     = d_ff;
      r_in     = r_ff;
      e_in     = e_ff;
      y_in     = y_ff;
      sq_in    = sq_ff;
      mstart   = 1'b0;
      ma       = y_ff;
      mb       = sq_ff;
      case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               x_in   = job.x;
               d_in   = job.d;
               r_in   = job.r;
               idx_in = '0;
               if (job.cls == mrpt_pkg::CLS_TEST) begin
                  prime_in = 1'b1;
                  state_in = S_BASE;
               end else begin
                  prime_in = job.cls == mrpt_pkg::CLS_PRIME;
                  state_in = S_OUT;
               end
            end
         end
         S_BASE: begin
            if (idx_ff == mrpt_pkg::IdxW'(mrpt_pkg::NumBases) || base >= x_ff) begin
               state_in = S_OUT;
            end else begin
               y_in     = mrpt_pkg::word_type'(1);
               sq_in    = base;
               e_in     = d_ff;
               wait_in  = 1'b0;
               state_in = S_EXP;
            end
         end
         S_EXP: begin
            if (!wait_ff) begin
               if (e_ff == '0) begin
                  state_in = S_CHECK;
                  i_in     = '0;
               end else begin
                  // Multiply y by sq when the bit is set, else square sq
                  mstart   = 1'b1;
                  sqmul_in = !e_ff[0];
                  ma       = e_ff[0] ? y_ff : sq_ff;
                  wait_in  = 1'b1;
               end
            end else if (mdone) begin
               wait_in = 1'b0;
               if (sqmul_ff) begin
                  sq_in = mp;
                  e_in  = e_ff >> 1;
               end else begin
                  y_in = mp;
                  e_in = {e_ff[mrpt_pkg::Width-1:1], 1'b0};
               end
            end
         end
         S_CHECK: begin
            if (y_ff == mrpt_pkg::word_type'(1)) begin
               idx_in   = idx_ff + mrpt_pkg::IdxW'(1);
               state_in = S_BASE;
            end else if (i_ff == r_ff) begin
               prime_in = 1'b0;
               state_in = S_OUT;
            end else if (y_ff == x_ff - mrpt_pkg::word_type'(1)) begin
               idx_in   = idx_ff + mrpt_pkg::IdxW'(1);
               state_in = S_BASE;
            end else begin
               mstart   = 1'b1;
               ma       = y_ff;
               mb       = y_ff;
               wait_in  = 1'b1;
               state_in = S_SQR;
            end
         end
         S_SQR: begin
            mb = y_ff;
            if (mdone) begin
               y_in     = mp;
               i_in     = i_ff + mrpt_pkg::RW'(1);
               wait_in  = 1'b0;
               // A squared value of 1 can never reach x-1 again
               state_in = (mp == mrpt_pkg::word_type'(1)) ? S_OUT : S_CHECK;
               if (mp == mrpt_pkg::word_type'(1)) begin
                  prime_in = 1'b0;
               end
            end
         end
         S_OUT: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_EXP && !wait_ff && e_ff != '0 && !e_ff[0]) begin
         mb = sq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wait_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
      end
      sqmul_ff <= sqmul_in;
      prime_ff <= prime_in;
      idx_ff   <= idx_in;
      i_ff     <= i_in;
      x_ff     <= x_in;
      d_ff     <= d_in;
      r_ff     <= r_in;
      e_ff     <= e_in;
      y_ff     <= y_in;
      sq_ff    <= sq_in;
   end
endmodule
`default_nettype wire

// ===== design/miller_rabin_primality_test_unit.sv =====
// ---------------------------------------------------------------------------
// miller_rabin_primality_test_unit
// Deterministic Miller-Rabin test of a 64-bit candidate against 13 bases.
// ---------------------------------------------------------------------------
// One word in, one word out. The front stage classifies each candidate and
// strips the trailing zeros of x-1 at one bit a cycle, then hands the job
// over a two-entry queue to the back stage, which runs every witness round
// on one shared shift-and-add modular multiplier. A base costs at most
// 128-r products (bit length of d squarings, popcount of d multiplies and
// r final squarings), so a full test of 13 bases is up to 13 x 127
// products; trivial cases (even, 0, 1, 2) are classified by the front
// stage and skip the witness rounds.
`default_nettype none
`include "miller_rabin_primality_test_unit_macros.svh"
module miller_rabin_primality_test_unit (
   input wire logic clock,
   input wire logic reset,
   mrpt_if.sink     req,
   mrpt_if.source   rsp
);
   logic              job_valid, job_ready, q_valid, q_ready;
   mrpt_pkg::job_type job, q_job;
   logic              res_valid, res_prime;

   mrpt_front u_front (
      .clock (clock), .reset (reset),
      .in_valid (req.valid), .in_ready (req.ready), .in_cand (req.data),
      .job_valid (job_valid), .job_ready (job_ready), .job (job)
   );

   mrpt_queue u_queue (
      .clock (clock), .reset (reset),
      .wr_valid (job_valid), .wr_ready (job_ready), .wr_job (job),
      .rd_valid (q_valid), .rd_ready (q_ready), .rd_job (q_job)
   );

   mrpt_back u_back (
      .clock (clock), .reset (reset),
      .job_valid (q_valid), .job_ready (q_ready), .job (q_job),
      .res_valid (res_valid), .res_ready (rsp.ready), .res_prime (res_prime)
   );

   assign rsp.valid = res_valid;
   assign rsp.data  = res_prime;

   // Even candidates above two are never reported prime
   `MR_ASSERT_IMPL(a_even_comp, clock, reset,
      job_valid && job_ready && job.x[0] == 1'b0 && job.x != 64'd2,
      job.cls == mrpt_pkg::CLS_COMPOSITE, "even candidate not composite")
   // Hold a stalled result and its word until taken
   `MR_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.data),
      "result dropped while stalled")
endmodule
`default_nettype wire
